/* hdl/dmarwc_pkg.sv */
package dmarwc_pkg;

  // Argument kinds expected next in a sequence
  typedef logic [3:0] kind_t;
  localparam kind_t K_BASE = 4'd0;
  localparam kind_t K_BYTE = 4'd1;
  localparam kind_t K_WORD = 4'd2;
  localparam kind_t K_TIMA = 4'd3;
  localparam kind_t K_TIMB = 4'd4;
  localparam kind_t K_MASK = 4'd5;
  localparam kind_t K_DONE = 4'd6;

  // Register groups
  localparam logic [2:0] GRP_WR0 = 3'd0;
  localparam logic [2:0] GRP_WR1 = 3'd1;
  localparam logic [2:0] GRP_WR2 = 3'd2;
  localparam logic [2:0] GRP_WR3 = 3'd3;
  localparam logic [2:0] GRP_WR4 = 3'd4;
  localparam logic [2:0] GRP_WR5 = 3'd5;
  localparam logic [2:0] GRP_WR6 = 3'd6;

  localparam logic [3:0] ERR_NONE    = 4'd0;
  localparam logic [3:0] ERR_BASE    = 4'd1;
  localparam logic [3:0] ERR_MISSING = 4'd2;
  localparam logic [3:0] ERR_TIMA    = 4'd3;
  localparam logic [3:0] ERR_TIMB    = 4'd4;
  localparam logic [3:0] ERR_INTR    = 4'd5;
  localparam logic [3:0] ERR_MODE    = 4'd6;
  localparam logic [3:0] ERR_CMD     = 4'd7;
  localparam logic [3:0] ERR_MASK    = 4'd8;
  localparam logic [3:0] ERR_EXTRA   = 4'd9;
  localparam logic [3:0] ERR_RANGE   = 4'd10;
  localparam logic [3:0] ERR_CPU     = 4'd11;

  localparam logic [2:0] WARN_NONE    = 3'd0;
  localparam logic [2:0] WARN_HALFCYC = 3'd1;
  localparam logic [2:0] WARN_UNSUPP  = 3'd2;
  localparam logic [2:0] WARN_READY   = 3'd3;
  localparam logic [2:0] WARN_UNIMPL  = 3'd4;

  // Configuration register index
  localparam logic REG_TARGET_HAS_DMA = 1'b0;

  // Commands of WR6
  localparam logic [7:0] CMD_RESET      = 8'hC3;
  localparam logic [7:0] CMD_LOAD       = 8'hCF;
  localparam logic [7:0] CMD_CONTINUE   = 8'hD3;
  localparam logic [7:0] CMD_DISABLE    = 8'h83;
  localparam logic [7:0] CMD_ENABLE     = 8'h87;
  localparam logic [7:0] CMD_READ_MASK  = 8'hBB;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [3:0] err;
    logic [2:0] warn;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [3:0] err;
    logic [7:0] bval;
    logic [2:0] warn;
    kind_t      ka;
    kind_t      kb;
  } base_t;

  function automatic kind_t pair_kind(input logic [1:0] bits);
    kind_t k;
    if (bits == 2'b11) k = K_WORD;
    else if (bits != 2'b00) k = K_BYTE;
    else k = K_BASE;
    return k;
  endfunction

  function automatic logic is_unimpl_cmd(input logic [7:0] n);
    logic r;
    unique case (n)
      8'h8B, 8'hA3, 8'hA7, 8'hAB, 8'hAF, 8'hB3,
      8'hB7, 8'hBF, CMD_RESET, 8'hC7, 8'hCB: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Check a base byte against its group; gives the byte to emit and the
  // arguments it calls for
  function automatic base_t base_eval(input logic [2:0] g, input logic [7:0] v);
    base_t      r;
    logic [7:0] n;
    n      = v;
    r.err  = ERR_NONE;
    r.warn = WARN_NONE;
    r.ka   = K_BASE;
    r.kb   = K_BASE;
    unique case (g)
      GRP_WR0: begin
        if ((n & 8'h83) != 8'h01) r.err = ERR_BASE;
        r.ka = pair_kind(n[4:3]);
        r.kb = pair_kind(n[6:5]);
      end
      GRP_WR1: begin
        if (((n & 8'h87) | 8'h04) != 8'h04) r.err = ERR_BASE;
        n = n | 8'h04;
        r.ka = n[6] ? K_TIMA : K_BASE;
      end
      GRP_WR2: begin
        if ((n & 8'h87) != 8'h00) r.err = ERR_BASE;
        r.ka = n[6] ? K_TIMB : K_BASE;
      end
      GRP_WR3: begin
        if (((n & 8'h83) | 8'h80) != 8'h80) r.err = ERR_BASE;
        n = n | 8'h80;
        if ((n & 8'h64) != 8'h00) r.warn = WARN_UNSUPP;
        r.ka = n[3] ? K_BYTE : K_BASE;
        r.kb = n[4] ? K_BYTE : K_BASE;
      end
      GRP_WR4: begin
        if (((n & 8'h83) | 8'h81) != 8'h81) r.err = ERR_BASE;
        else if (n[4]) r.err = ERR_INTR;
        else if (n[6:5] == 2'b00 || n[6:5] == 2'b11) r.err = ERR_MODE;
        n = n | 8'h81;
        if (n[3:2] == 2'b11) begin
          r.ka = K_WORD;
        end else begin
          r.ka = n[2] ? K_BYTE : K_BASE;
          r.kb = n[3] ? K_BYTE : K_BASE;
        end
      end
      GRP_WR5: begin
        if (((n & 8'hC7) | 8'h82) != 8'h82) r.err = ERR_BASE;
        n = n | 8'h82;
        if (n[3]) r.warn = WARN_READY;
      end
      GRP_WR6: begin
        if (is_unimpl_cmd(n)) r.warn = WARN_UNIMPL;
        else if (n != CMD_DISABLE && n != CMD_ENABLE && n != CMD_READ_MASK &&
                 n != CMD_LOAD && n != CMD_CONTINUE) r.err = ERR_CMD;
        r.ka = (n == CMD_READ_MASK) ? K_MASK : K_BASE;
      end
      default: begin
        r.err = ERR_BASE;
      end
    endcase
    r.bval = n;
    return r;
  endfunction

endpackage

/* hdl/dmarwc_apb.sv */
module dmarwc_apb
  import dmarwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        has_dma_o
);

  logic has_dma_q;
  logic has_dma_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr[2] == REG_TARGET_HAS_DMA);

  always_comb begin
    has_dma_d = has_dma_q;
    if (wr_en) has_dma_d = pwdata[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_dma_q <= 1'b1;
    end else begin
      has_dma_q <= has_dma_d;
    end
  end

  assign prdata    = (paddr[2] == REG_TARGET_HAS_DMA) ? {31'd0, has_dma_q} : 32'd0;
  assign has_dma_o = has_dma_q;

endmodule

/* hdl/dmarwc_core.sv */
module dmarwc_core
  import dmarwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic        has_dma_i,
  input  logic [2:0]  mode_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [15:0] value_i,
  output logic [1:0]  nres_o,
  output res_t        res0_o,
  output res_t        res1_o
);

  kind_t      expect_q, expect_d;
  logic [2:0] pending_q, pending_d;
  logic       skip_q, skip_d;

  base_t      base;
  logic [3:0] err;
  logic [2:0] warn;
  logic       live;
  logic       hi_zero;

  assign base    = base_eval(mode_i, value_i[7:0]);
  assign hi_zero = (value_i[15:8] == 8'd0);

  always_comb begin
    expect_d  = expect_q;
    pending_d = pending_q;
    skip_d    = skip_q;
    nres_o    = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    err       = ERR_NONE;
    warn      = WARN_NONE;
    live      = 1'b0;

    if (first_i) begin
      live      = 1'b1;
      expect_d  = K_BASE;
      pending_d = 3'd0;
      skip_d    = 1'b0;
      nres_o    = 2'd1;
      if (!has_dma_i) err = ERR_CPU;
      else if (!hi_zero) err = ERR_RANGE;
      else err = base.err;
      if (err == ERR_NONE) begin
        res0_o.valid = 1'b1;
        res0_o.data  = base.bval;
        res0_o.warn  = base.warn;
        // queue up to two arguments, empty slots close up
        if (base.ka == K_BASE) begin
          expect_d  = (base.kb == K_BASE) ? K_DONE : base.kb;
          pending_d = 3'd0;
        end else begin
          expect_d  = base.ka;
          pending_d = base.kb[2:0];
        end
      end else begin
        res0_o.err = err;
      end
    end else if (expect_q == K_BASE) begin
      // drop stray item
    end else if (skip_q) begin
      if (last_i) begin
        expect_d  = K_BASE;
        pending_d = 3'd0;
        skip_d    = 1'b0;
      end
    end else begin
      live   = 1'b1;
      nres_o = 2'd1;
      unique case (expect_q)
        K_BYTE: begin
          res0_o.valid = 1'b1;
          res0_o.data  = value_i[7:0];
          expect_d     = (pending_q != 3'd0) ? {1'b0, pending_q} : K_DONE;
          pending_d    = 3'd0;
        end
        K_WORD: begin
          nres_o       = 2'd2;
          res0_o.valid = 1'b1;
          res0_o.data  = value_i[7:0];
          res1_o.valid = 1'b1;
          res1_o.data  = value_i[15:8];
          expect_d     = (pending_q != 3'd0) ? {1'b0, pending_q} : K_DONE;
          pending_d    = 3'd0;
        end
        K_TIMA, K_TIMB: begin
          if (!hi_zero) begin
            err = ERR_RANGE;
            res0_o.err = err;
          end else begin
            if (expect_q == K_TIMA) begin
              if (value_i[5:4] != 2'b00 || value_i[1:0] == 2'b11) err = ERR_TIMA;
            end else begin
              if (value_i[4] || value_i[1:0] == 2'b11) err = ERR_TIMB;
            end
            if (err == ERR_NONE && (value_i[7:0] & 8'hCC) != 8'h00) warn = WARN_HALFCYC;
            res0_o.valid = 1'b1;
            res0_o.data  = value_i[7:0];
            res0_o.err   = err;
            res0_o.warn  = warn;
            if (err == ERR_NONE) begin
              if (expect_q == K_TIMB && value_i[5]) begin
                expect_d  = K_BYTE;
                pending_d = 3'd0;
              end else begin
                expect_d  = (pending_q != 3'd0) ? {1'b0, pending_q} : K_DONE;
                pending_d = 3'd0;
              end
            end
          end
        end
        K_MASK: begin
          if (!hi_zero) err = ERR_RANGE;
          else if (value_i[7]) err = ERR_MASK;
          if (err != ERR_NONE) begin
            res0_o.err = err;
          end else begin
            res0_o.valid = 1'b1;
            res0_o.data  = value_i[7:0];
            expect_d     = (pending_q != 3'd0) ? {1'b0, pending_q} : K_DONE;
            pending_d    = 3'd0;
          end
        end
        default: begin
          err = ERR_EXTRA;
          res0_o.err = err;
        end
      endcase
    end

    if (live) begin
      if (err != ERR_NONE) begin
        if (last_i) begin
          expect_d  = K_BASE;
          pending_d = 3'd0;
          skip_d    = 1'b0;
        end else begin
          skip_d = 1'b1;
        end
      end else if (last_i) begin
        if (expect_d != K_DONE) begin
          if (nres_o == 2'd2) res1_o.err = ERR_MISSING;
          else res0_o.err = ERR_MISSING;
        end
        expect_d  = K_BASE;
        pending_d = 3'd0;
        skip_d    = 1'b0;
      end
      if (nres_o == 2'd2) res1_o.last = 1'b1;
      else res0_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q  <= K_BASE;
      pending_q <= 3'd0;
      skip_q    <= 1'b0;
    end else if (fire_i) begin
      expect_q  <= expect_d;
      pending_q <= pending_d;
      skip_q    <= skip_d;
    end
  end

endmodule

/* hdl/dmarwc_outbuf.sv */
module dmarwc_outbuf
  import dmarwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [1:0]  nres_i,
  input  res_t        res0_i,
  input  res_t        res1_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // emitted_byte[7:0], error_code[11:8], warning_code[14:12]
  output logic [0:0]  m_axis_tuser,  // byte_valid[0]
  output logic        m_axis_tlast
);

  logic [1:0] cnt_q, cnt_d;
  res_t       r0_q, r0_d;
  res_t       r1_q, r1_d;
  logic       take;

  assign take   = m_axis_tvalid & m_axis_tready;
  assign free_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);

  always_comb begin
    cnt_d = cnt_q;
    r0_d  = r0_q;
    r1_d  = r1_q;
    if (take) begin
      // advance the second result into the head slot
      if (cnt_q == 2'd2) begin
        r0_d  = r1_q;
        cnt_d = 2'd1;
      end else begin
        cnt_d = 2'd0;
      end
    end
    if (load_i) begin
      r0_d  = res0_i;
      r1_d  = res1_i;
      cnt_d = nres_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {1'b0, r0_q.warn, r0_q.err, r0_q.data};
  assign m_axis_tuser  = r0_q.valid;
  assign m_axis_tlast  = r0_q.last;

endmodule

/* hdl/dma_register_write_checker_top.sv */
// An accepted item is held in the input register; once the output buffer is free its results are
// registered there. Throughput: one item per cycle while the output side accepts; a word argument
// gives two byte results that leave the buffer one at a time, so such an item holds up the next.
// Items that cause no result pass through the input register and load nothing into the output buffer.
// Reset: sequence state returns to expecting a base byte, target_has_dma goes to 1.
module dma_register_write_checker_top
  import dmarwc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // arg_value[15:0]
  input  logic [3:0]  s_axis_tuser,  // mode[2:0], first_arg[3]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // emitted_byte[7:0], error_code[11:8], warning_code[14:12]
  output logic [0:0]  m_axis_tuser,  // byte_valid[0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_vld_q, in_vld_d;
  logic [2:0]  mode_q;
  logic        first_q;
  logic        last_q;
  logic [15:0] value_q;

  logic        has_dma;
  logic        out_free;
  logic        fire;
  logic [1:0]  nres;
  res_t        res0;
  res_t        res1;

  dmarwc_apb u_apb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .has_dma_o (has_dma)
  );

  assign fire          = in_vld_q & out_free;
  assign s_axis_tready = ~in_vld_q | out_free;

  always_comb begin
    in_vld_d = in_vld_q;
    if (fire) in_vld_d = 1'b0;
    if (s_axis_tvalid && s_axis_tready) in_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q  <= s_axis_tuser[2:0];
      first_q <= s_axis_tuser[3];
      last_q  <= s_axis_tlast;
      value_q <= s_axis_tdata;
    end
  end

  dmarwc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .has_dma_i (has_dma),
    .mode_i    (mode_q),
    .first_i   (first_q),
    .last_i    (last_q),
    .value_i   (value_q),
    .nres_o    (nres),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  dmarwc_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (fire && nres != 2'd0),
    .nres_i        (nres),
    .res0_i        (res0),
    .res1_i        (res1),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* tb/dma_register_write_checker_top_tb.sv */
`timescale 1ns / 1ps

import dmarwc_pkg::*;

class write_seq_board;
  bit       dma_ok;
  kind_t    want;
  kind_t    queued;
  bit [2:0] group;
  bit       skipping;
  res_t     expected[$];
  res_t     item_res[2];
  int       item_cnt;
  int       mismatches;

  function new();
    dma_ok     = 1'b1;
    mismatches = 0;
    go_idle();
    group = GRP_WR0;
  endfunction

  static function bit [7:0] unimpl_code(int i);
    bit [7:0] c;
    case (i)
      0: c = 8'h8B;
      1: c = 8'hA3;
      2: c = 8'hA7;
      3: c = 8'hAB;
      4: c = 8'hAF;
      5: c = 8'hB3;
      6: c = 8'hB7;
      7: c = 8'hBF;
      8: c = CMD_RESET;
      9: c = 8'hC7;
      default: c = 8'hCB;
    endcase
    return c;
  endfunction

  function void go_idle();
    want     = K_BASE;
    queued   = K_BASE;
    skipping = 1'b0;
  endfunction

  function void enqueue(kind_t a, kind_t b);
    if (a == K_BASE) begin
      a = b;
      b = K_BASE;
    end
    want   = (a == K_BASE) ? K_DONE : a;
    queued = b;
  endfunction

  function void step_on();
    if (queued != K_BASE) begin
      want   = queued;
      queued = K_BASE;
    end else begin
      want = K_DONE;
    end
  endfunction

  static function kind_t arg_kind(bit [1:0] bits);
    if (bits == 2'b11) return K_WORD;
    if (bits != 2'b00) return K_BYTE;
    return K_BASE;
  endfunction

  // Check a base byte of group g; no state is touched, so stimulus may ask too
  function bit [3:0] eval_base(input bit [2:0] g, input bit [7:0] v, output bit [7:0] n,
                               output bit [2:0] w, output kind_t ka, output kind_t kb);
    bit unimpl;
    n  = v;
    w  = WARN_NONE;
    ka = K_BASE;
    kb = K_BASE;
    unimpl = 1'b0;
    case (g)
      GRP_WR0: begin
        if ((n & 8'h83) != 8'h01) return ERR_BASE;
        ka = arg_kind(n[4:3]);
        kb = arg_kind(n[6:5]);
      end
      GRP_WR1: begin
        if (((n & 8'h87) | 8'h04) != 8'h04) return ERR_BASE;
        n  = n | 8'h04;
        ka = n[6] ? K_TIMA : K_BASE;
      end
      GRP_WR2: begin
        if ((n & 8'h87) != 8'h00) return ERR_BASE;
        ka = n[6] ? K_TIMB : K_BASE;
      end
      GRP_WR3: begin
        if (((n & 8'h83) | 8'h80) != 8'h80) return ERR_BASE;
        n = n | 8'h80;
        if ((n & 8'h64) != 8'h00) w = WARN_UNSUPP;
        ka = n[3] ? K_BYTE : K_BASE;
        kb = n[4] ? K_BYTE : K_BASE;
      end
      GRP_WR4: begin
        if (((n & 8'h83) | 8'h81) != 8'h81) return ERR_BASE;
        if (n[4]) return ERR_INTR;
        if (n[6:5] == 2'b00 || n[6:5] == 2'b11) return ERR_MODE;
        n = n | 8'h81;
        if (n[3:2] == 2'b11) begin
          ka = K_WORD;
        end else begin
          ka = n[2] ? K_BYTE : K_BASE;
          kb = n[3] ? K_BYTE : K_BASE;
        end
      end
      GRP_WR5: begin
        if (((n & 8'hC7) | 8'h82) != 8'h82) return ERR_BASE;
        n = n | 8'h82;
        if (n[3]) w = WARN_READY;
      end
      GRP_WR6: begin
        for (int i = 0; i < 11; i++)
          if (n == unimpl_code(i)) unimpl = 1'b1;
        if (unimpl) w = WARN_UNIMPL;
        else if (n != CMD_DISABLE && n != CMD_ENABLE && n != CMD_READ_MASK &&
                 n != CMD_LOAD && n != CMD_CONTINUE) return ERR_CMD;
        ka = (n == CMD_READ_MASK) ? K_MASK : K_BASE;
      end
      default: return ERR_BASE;
    endcase
    return ERR_NONE;
  endfunction

  function void add_res(bit v, bit [7:0] b, bit [3:0] e, bit [2:0] w);
    item_res[item_cnt].valid = v;
    item_res[item_cnt].data  = v ? b : 8'h00;
    item_res[item_cnt].err   = e;
    item_res[item_cnt].warn  = w;
    item_res[item_cnt].last  = 1'b0;
    item_cnt++;
  endfunction

  // Work out the results of one accepted argument and queue them
  function void note_arg(bit [2:0] mode, bit first, bit last, bit [15:0] v);
    bit [3:0] err;
    bit [2:0] warn;
    bit [7:0] b;
    kind_t    ka;
    kind_t    kb;
    err      = ERR_NONE;
    warn     = WARN_NONE;
    item_cnt = 0;
    if (first) begin
      go_idle();
      group = mode;
      if (!dma_ok) err = ERR_CPU;
      else if (v > 16'd255) err = ERR_RANGE;
      else begin
        err = eval_base(mode, v[7:0], b, warn, ka, kb);
        if (err == ERR_NONE) enqueue(ka, kb);
      end
      if (err != ERR_NONE) add_res(1'b0, 8'h00, err, WARN_NONE);
      else add_res(1'b1, b, ERR_NONE, warn);
    end else begin
      if (want == K_BASE) return;
      if (skipping) begin
        if (last) go_idle();
        return;
      end
      case (want)
        K_BYTE: begin
          add_res(1'b1, v[7:0], ERR_NONE, WARN_NONE);
          step_on();
        end
        K_WORD: begin
          add_res(1'b1, v[7:0], ERR_NONE, WARN_NONE);
          add_res(1'b1, v[15:8], ERR_NONE, WARN_NONE);
          step_on();
        end
        K_TIMA, K_TIMB: begin
          if (v > 16'd255) begin
            err = ERR_RANGE;
            add_res(1'b0, 8'h00, err, WARN_NONE);
          end else begin
            if (want == K_TIMA) begin
              if (v[5:4] != 2'b00 || v[1:0] == 2'b11) err = ERR_TIMA;
            end else begin
              if (v[4] || v[1:0] == 2'b11) err = ERR_TIMB;
            end
            if (err == ERR_NONE && (v[7:0] & 8'hCC) != 8'h00) warn = WARN_HALFCYC;
            add_res(1'b1, v[7:0], err, warn);
            if (err == ERR_NONE) begin
              // port B timing may call for one more byte
              if (want == K_TIMB && v[5]) enqueue(K_BYTE, K_BASE);
              else step_on();
            end
          end
        end
        K_MASK: begin
          if (v > 16'd255) err = ERR_RANGE;
          else if (v[7]) err = ERR_MASK;
          if (err != ERR_NONE) add_res(1'b0, 8'h00, err, WARN_NONE);
          else begin
            add_res(1'b1, v[7:0], ERR_NONE, WARN_NONE);
            step_on();
          end
        end
        default: begin
          err = ERR_EXTRA;
          add_res(1'b0, 8'h00, err, WARN_NONE);
        end
      endcase
    end
    if (err != ERR_NONE) begin
      if (last) go_idle();
      else skipping = 1'b1;
    end else if (last) begin
      if (want != K_DONE) item_res[item_cnt - 1].err = ERR_MISSING;
      go_idle();
    end
    item_res[item_cnt - 1].last = 1'b1;
    for (int i = 0; i < item_cnt; i++) expected.push_back(item_res[i]);
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function void check_byte(logic v, logic [7:0] b, logic [3:0] e, logic [2:0] w, logic l);
    res_t exp_r;
    if (expected.size() == 0) begin
      flag($sformatf("unexpected result: valid %0d byte %02h err %0d warn %0d end %0d",
                     v, b, e, w, l));
      return;
    end
    exp_r = expected.pop_front();
    if (exp_r.valid !== v || exp_r.data !== b || exp_r.err !== e || exp_r.warn !== w ||
        exp_r.last !== l)
      flag($sformatf({"mismatch: expected valid %0d byte %02h err %0d warn %0d end %0d, ",
                      "got valid %0d byte %02h err %0d warn %0d end %0d"},
                     exp_r.valid, exp_r.data, exp_r.err, exp_r.warn, exp_r.last,
                     v, b, e, w, l));
  endfunction
endclass

module dma_register_write_checker_top_tb;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = 16'h0000;  // arg_value[15:0]
  logic [3:0]  s_axis_tuser = 4'h0;      // mode[2:0], first_arg[3]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // emitted_byte[7:0], error_code[11:8], warning_code[14:12]
  logic [0:0]  m_axis_tuser;  // byte_valid[0]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  write_seq_board board;
  int          sent_items = 0;
  int          cycles = 0;
  logic        calm;

  // no idling on either side through this stretch
  assign calm = (sent_items >= 300 && sent_items < 420);

  dma_register_write_checker_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_byte(m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[11:8],
                       m_axis_tdata[14:12], m_axis_tlast);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dma_register_write_checker_top_tb: done, errors");
      $finish;
    end
  end

  task automatic send_arg(input bit [2:0] mode, input bit first, input bit last,
                          input bit [15:0] v);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= {first, mode};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_arg(mode, first, last, v);
    sent_items++;
  endtask

  // drop valid, drain every expected result, then give the block time to go quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.expected.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_target_dma(input bit on);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_TARGET_HAS_DMA);
    pwdata  <= {31'd0, on};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.dma_ok = on;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic bit [7:0] pick_command();
    int i;
    i = $urandom_range(0, 15);
    if (i < 11) return board.unimpl_code(i);
    case (i)
      11: return CMD_DISABLE;
      12: return CMD_ENABLE;
      13: return CMD_READ_MASK;
      14: return CMD_LOAD;
      default: return CMD_CONTINUE;
    endcase
  endfunction

  // a base byte that passes the checks of its group (WR0 to WR6), with random free bits
  function automatic bit [7:0] legal_base(bit [2:0] g);
    bit [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (g)
      GRP_WR0: r = (r & 8'h7C) | 8'h01;
      GRP_WR1: r = r & 8'h7C;
      GRP_WR2: r = r & 8'h78;
      GRP_WR3: r = r & 8'hFC;
      GRP_WR4: r = (r & 8'h8D) | (r[1] ? 8'h20 : 8'h40);
      GRP_WR5: r = r & 8'hBA;
      GRP_WR6: r = pick_command();
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit [15:0] arg_for(kind_t k);
    bit [15:0] v;
    bit [7:0]  t;
    t = 8'($urandom_range(0, 255));
    v = {8'h00, t};
    case (k)
      K_WORD: v = 16'($urandom_range(0, 65535));
      K_BYTE: if ($urandom_range(0, 9) == 0) v = 16'($urandom_range(256, 65535));
      K_TIMA, K_TIMB: begin
        if ($urandom_range(0, 19) == 0) v = 16'($urandom_range(256, 65535));
        else if ($urandom_range(0, 5) != 0) begin
          t[4] = 1'b0;
          if (k == K_TIMA) t[5] = 1'b0;
          if (t[1:0] == 2'b11) t[1] = 1'b0;
          v = {8'h00, t};
        end
      end
      K_MASK: begin
        if ($urandom_range(0, 19) == 0) v = 16'($urandom_range(256, 65535));
        else if ($urandom_range(0, 5) != 0) v = {9'h000, t[6:0]};
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_sequence();
    bit [2:0]  g;
    bit [15:0] v;
    bit [7:0]  nb;
    bit [3:0]  e;
    bit [2:0]  w;
    kind_t     ka;
    kind_t     kb;
    bit        extra;
    bit        drop;
    bit        fin;
    bit        cut;
    int        tail;
    if ($urandom_range(0, 99) < 8) begin
      send_arg(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 16'($urandom));
      return;
    end
    g = ($urandom_range(0, 39) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    case ($urandom_range(0, 19))
      0: v = 16'($urandom_range(256, 65535));
      1, 2, 3: v = 16'($urandom_range(0, 255));
      default: v = {8'h00, legal_base(g)};
    endcase
    e = board.eval_base(g, v[7:0], nb, w, ka, kb);
    if (!board.dma_ok) e = ERR_CPU;
    else if (v > 16'd255) e = ERR_RANGE;
    if (e != ERR_NONE) begin
      // failed base: follow it with up to two arguments that get skipped
      tail = $urandom_range(0, 2);
      send_arg(g, 1'b1, tail == 0, v);
      for (int i = 0; i < tail; i++)
        send_arg(3'($urandom_range(0, 7)), 1'b0, i == tail - 1, 16'($urandom));
      return;
    end
    extra = ($urandom_range(0, 9) == 0);
    drop  = ($urandom_range(0, 9) == 0);
    send_arg(g, 1'b1, ka == K_BASE && !extra, v);
    while (board.want != K_DONE && board.want != K_BASE && !board.skipping) begin
      v   = arg_for(board.want);
      fin = board.queued == K_BASE && !(board.want == K_TIMB && v[5]);
      cut = drop && $urandom_range(0, 1) == 0;
      send_arg(3'($urandom_range(0, 7)), 1'b0, (fin && !extra) || cut, v);
    end
    // close a failed sequence, or add the planned surplus argument
    if (board.skipping || board.want == K_DONE)
      send_arg(3'($urandom_range(0, 7)), 1'b0, 1'b1, 16'($urandom));
  endtask

  initial begin
    board = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_arg(GRP_WR0, 1'b0, 1'b0, 16'h0055);    // stray argument
    send_arg(GRP_WR0, 1'b1, 1'b0, 16'h0079);    // two words follow
    send_arg(3'd7,    1'b0, 1'b0, 16'hFFFF);
    send_arg(GRP_WR3, 1'b0, 1'b1, 16'h0000);
    send_arg(GRP_WR1, 1'b1, 1'b1, 16'h0040);    // timing byte missing
    send_arg(GRP_WR2, 1'b1, 1'b0, 16'h0040);
    send_arg(GRP_WR2, 1'b0, 1'b0, 16'h002C);    // half cycle, calls for a byte
    send_arg(GRP_WR2, 1'b0, 1'b1, 16'h01FF);    // free byte above 255
    send_arg(GRP_WR2, 1'b1, 1'b0, 16'h0040);
    send_arg(GRP_WR2, 1'b0, 1'b0, 16'h0013);    // bad port B timing
    send_arg(GRP_WR2, 1'b0, 1'b1, 16'h0000);    // skipped
    send_arg(GRP_WR1, 1'b1, 1'b0, 16'h0040);
    send_arg(GRP_WR1, 1'b0, 1'b1, 16'h0030);    // bad port A timing
    send_arg(GRP_WR3, 1'b1, 1'b0, 16'h007C);
    send_arg(GRP_WR3, 1'b0, 1'b0, 16'h0000);
    send_arg(GRP_WR3, 1'b0, 1'b1, 16'h00FF);
    send_arg(GRP_WR4, 1'b1, 1'b0, 16'h002D);    // word pending, then dropped
    send_arg(GRP_WR4, 1'b1, 1'b1, 16'h0095);    // interrupt bit
    send_arg(GRP_WR4, 1'b1, 1'b1, 16'h0001);    // no transfer mode
    send_arg(GRP_WR5, 1'b1, 1'b1, 16'h0008);
    send_arg(GRP_WR6, 1'b1, 1'b0, {8'h00, CMD_READ_MASK});
    send_arg(GRP_WR6, 1'b0, 1'b1, 16'h0080);    // bad read mask
    send_arg(GRP_WR6, 1'b1, 1'b1, {8'h00, CMD_RESET});
    send_arg(GRP_WR6, 1'b1, 1'b1, 16'h0000);    // unknown command
    send_arg(3'd7,    1'b1, 1'b1, 16'h0000);    // no such group
    send_arg(GRP_WR5, 1'b1, 1'b1, 16'h0100);    // base above 255
    send_arg(GRP_WR5, 1'b1, 1'b0, 16'h0000);
    send_arg(GRP_WR5, 1'b0, 1'b1, 16'h0012);    // one argument too many

    settle();
    set_target_dma(1'b0);
    repeat (15) random_sequence();
    settle();
    set_target_dma(1'b1);
    while (sent_items < 625) random_sequence();
    settle();
    repeat (10) @(posedge clk_i);

    if (board.mismatches == 0)
      $display("dma_register_write_checker_top_tb: done, clean");
    else
      $display("dma_register_write_checker_top_tb: done, errors");
    $finish;
  end

endmodule
